### sv/cxpd_pkg.sv
package cxpd_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic [PADDR_W-3:0] REG_OUTER_KEY = 1'b0;

    typedef logic [DATA_W-1:0] byte_t;

    typedef struct packed {
        byte_t cipher_byte;
        byte_t random_key;
        logic  first_byte;
        logic  last_byte;
    } in_word_t;

    typedef struct packed {
        byte_t plain_byte;
        logic  is_checksum;
        logic  end_of_packet;
        logic  checksum_ok;
    } out_word_t;

endpackage

### sv/chained_xor_packet_decoder.sv
// A word accepted at a clock edge appears on out_data in the next cycle, from the output register.
// Throughput: one word per cycle while out_ready is high; the output register refills in the cycle it is taken.
// The per-byte chain is an 8-bit increment, four 8-bit adds and two XORs ahead of the output register.
// Reset (rst_n low, asynchronous) clears the outer key, the chain, position, sum,
// checksum and held key to zero and empties the output register.
module chained_xor_packet_decoder
    import cxpd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  in_word_t            in_data,

    output logic                out_valid,
    input  logic                out_ready,
    output out_word_t           out_data,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    byte_t     outer_key_reg;
    byte_t     prev_cipher_reg;
    byte_t     prev_cipher_next;
    byte_t     prev_inter_reg;
    byte_t     prev_inter_next;
    byte_t     pos_reg;
    byte_t     pos_next;
    byte_t     sum_reg;
    byte_t     sum_next;
    byte_t     checksum_reg;
    byte_t     checksum_next;
    byte_t     rkey_reg;
    byte_t     rkey_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_word_t out_data_reg;
    out_word_t out_data_next;

    logic      in_fire;
    logic      cfg_write;
    byte_t     cur_prev_cipher;
    byte_t     cur_prev_inter;
    byte_t     cur_pos;
    byte_t     cur_sum;
    byte_t     cur_rkey;
    byte_t     step_pos;
    byte_t     inter;
    byte_t     plain;
    byte_t     new_sum;
    byte_t     new_checksum;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[PADDR_W-1:2] == REG_OUTER_KEY)
                       ? {{(PDATA_W-DATA_W){1'b0}}, outer_key_reg}
                       : '0;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        // A start mark restarts the chain before this byte is decoded.
        cur_prev_cipher = in_data.first_byte ? '0 : prev_cipher_reg;
        cur_prev_inter  = in_data.first_byte ? '0 : prev_inter_reg;
        cur_pos         = in_data.first_byte ? '0 : pos_reg;
        cur_sum         = in_data.first_byte ? '0 : sum_reg;
        cur_rkey        = in_data.first_byte ? in_data.random_key : rkey_reg;

        step_pos = cur_pos + 8'd1;
        inter    = in_data.cipher_byte ^ (cur_prev_cipher + outer_key_reg + step_pos);
        plain    = inter ^ (cur_prev_inter + cur_rkey + step_pos);

        new_sum      = in_data.first_byte ? cur_sum : cur_sum + plain;
        new_checksum = in_data.first_byte ? plain : checksum_reg;

        prev_cipher_next = prev_cipher_reg;
        prev_inter_next  = prev_inter_reg;
        pos_next         = pos_reg;
        sum_next         = sum_reg;
        checksum_next    = checksum_reg;
        rkey_next        = rkey_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        if (in_fire)
        begin
            prev_cipher_next            = in_data.cipher_byte;
            prev_inter_next             = inter;
            pos_next                    = step_pos;
            sum_next                    = new_sum;
            checksum_next               = new_checksum;
            rkey_next                   = cur_rkey;
            out_valid_next              = 1'b1;
            out_data_next.plain_byte    = plain;
            out_data_next.is_checksum   = in_data.first_byte;
            out_data_next.end_of_packet = in_data.last_byte;
            out_data_next.checksum_ok   = in_data.last_byte && (new_sum == new_checksum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_key_reg   <= '0;
            prev_cipher_reg <= '0;
            prev_inter_reg  <= '0;
            pos_reg         <= '0;
            sum_reg         <= '0;
            checksum_reg    <= '0;
            rkey_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write && (paddr[PADDR_W-1:2] == REG_OUTER_KEY))
            begin
                outer_key_reg <= pwdata[DATA_W-1:0];
            end
            prev_cipher_reg <= prev_cipher_next;
            prev_inter_reg  <= prev_inter_next;
            pos_reg         <= pos_next;
            sum_reg         <= sum_next;
            checksum_reg    <= checksum_next;
            rkey_reg        <= rkey_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    a_ok_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.end_of_packet |-> !out_data_reg.checksum_ok)
        else $error("checksum_ok set on a word that does not end a packet");

    a_first_restarts_pos: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_data.first_byte |=> (pos_reg == 8'd1) && (sum_reg == 8'd0))
        else $error("start of packet did not restart position and sum");

    a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted word did not reach the output register");

    a_pos_advances: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !in_data.first_byte |=> pos_reg == $past(pos_reg) + 8'd1)
        else $error("position did not advance by one");

endmodule
